/* hw/rtl/amq_pkg.sv */
// Shared types and codes for the array min priority queue.
`timescale 1ns / 1ps
`default_nettype none

package amq_pkg;

	// Command field codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	// Result status codes
	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_REMOVED  = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    capture;     // latch input beat payload
		logic    ins_write;   // append held item at tail
		logic    scan_start;  // reset sweep index to zero
		logic    scan_step;   // read next entry and track minimum
		logic    shift_start; // point sweep index past the minimum
		logic    shift_step;  // move entries down one place
		logic    dec;         // drop one entry from the count
		logic    finish;      // load the result register
		status_t res;         // status for the result being loaded
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic empty;
		logic full;
		logic sweep_done;
	} dp_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/amq_datapath.sv */
// Datapath: entry store, sweep index, minimum tracker and result register.
`timescale 1ns / 1ps
`default_nettype none

module amq_datapath import amq_pkg::*; #(
	parameter int DEPTH = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dp_cmd_t            cmd,
	output dp_stat_t                stat,
	input  wire logic signed [31:0] value_in,
	input  wire logic signed [15:0] priority_in,
	output logic [1:0]              status,
	output logic signed [31:0]      value_out,
	output logic signed [15:0]      priority_out,
	output logic [3:0]              occupancy
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic signed [31:0] val_mem [DEPTH];
	logic signed [15:0] pri_mem [DEPTH];

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic signed [31:0] item_val_q;
	logic signed [15:0] item_pri_q;

	logic               rd_valid_s1;
	logic [AW-1:0]      rd_idx_s1;
	logic signed [31:0] rd_val_s1;
	logic signed [15:0] rd_pri_s1;

	logic [AW-1:0]      best_idx_q;
	logic signed [31:0] best_val_q;
	logic signed [15:0] best_pri_q;

	status_t            status_q;
	logic signed [31:0] value_out_q;
	logic signed [15:0] priority_out_q;
	logic [3:0]         occ_q;

	logic               rd_issue;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic signed [31:0] wr_val;
	logic signed [15:0] wr_pri;
	logic               take_best;

	assign rd_issue = (cmd.scan_step || cmd.shift_step) && (idx_q < count_q);

	// Insert writes the tail; shift writes each read beat one place lower
	assign wr_en   = cmd.ins_write || (cmd.shift_step && rd_valid_s1);
	assign wr_addr = cmd.ins_write ? count_q[AW-1:0] : rd_idx_s1 - AW'(1);
	assign wr_val  = cmd.ins_write ? item_val_q : rd_val_s1;
	assign wr_pri  = cmd.ins_write ? item_pri_q : rd_pri_s1;

	// Strict less-than keeps the earliest entry on a tie
	assign take_best = cmd.scan_step && rd_valid_s1 &&
		((rd_idx_s1 == '0) || (rd_pri_s1 < best_pri_q));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			val_mem[wr_addr] <= wr_val;
			pri_mem[wr_addr] <= wr_pri;
		end
		if (rd_issue) begin
			rd_val_s1 <= val_mem[idx_q[AW-1:0]];
			rd_pri_s1 <= pri_mem[idx_q[AW-1:0]];
			rd_idx_s1 <= idx_q[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_val_q <= value_in;
			item_pri_q <= priority_in;
		end
		if (take_best) begin
			best_idx_q <= rd_idx_s1;
			best_val_q <= rd_val_s1;
			best_pri_q <= rd_pri_s1;
		end
		if (cmd.finish) begin
			status_q       <= cmd.res;
			value_out_q    <= (cmd.res == ST_REMOVED) ? best_val_q : '0;
			priority_out_q <= (cmd.res == ST_REMOVED) ? best_pri_q : '0;
			occ_q          <= 4'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_issue;
			if (cmd.ins_write) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.dec) begin
				count_q <= count_q - CW'(1);
			end
			priority if (cmd.shift_start) begin
				idx_q <= CW'(best_idx_q) + CW'(1);
			end else if (cmd.scan_start) begin
				idx_q <= '0;
			end else if (rd_issue) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	assign stat.empty      = (count_q == '0);
	assign stat.full       = (count_q == CW'(DEPTH));
	assign stat.sweep_done = (idx_q >= count_q) && !rd_valid_s1;

	assign status       = status_q;
	assign value_out    = value_out_q;
	assign priority_out = priority_out_q;
	assign occupancy    = occ_q;

endmodule

`default_nettype wire

/* hw/rtl/amq_ctrl.sv */
// Controller: sequences insert, minimum scan, compaction and result handoff.
`timescale 1ns / 1ps
`default_nettype none

module amq_ctrl import amq_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire logic     command,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_INS   = 5'b00010,
		S_SCAN  = 5'b00100,
		S_SHIFT = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t  state_q, state_d;
	status_t res_q, res_d;
	logic    out_valid_q;

	always_comb begin
		cmd     = '0;
		cmd.res = res_q;
		state_d = state_q;
		res_d   = res_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (command == CMD_INSERT) begin
						res_d   = stat.full ? ST_FULL : ST_INSERTED;
						state_d = stat.full ? S_DONE : S_INS;
					end else if (stat.empty) begin
						res_d   = ST_EMPTY;
						state_d = S_DONE;
					end else begin
						res_d          = ST_REMOVED;
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end
				end
			end
			S_INS: begin
				cmd.ins_write = 1'b1;
				state_d       = S_DONE;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.sweep_done) begin
					cmd.shift_start = 1'b1;
					state_d         = S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (stat.sweep_done) begin
					cmd.dec = 1'b1;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// wait here until the result register is free
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_q       <= ST_INSERTED;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* hw/rtl/array_min_priority_queue.sv */
// Top level of the array min priority queue.
//
//   channel | signals                                  | dir | handshake
//   --------+------------------------------------------+-----+---------------------
//   in      | command, value_in, priority_in           | in  | in_valid / in_ready
//   out     | status, value_out, priority_out, occupancy| out | out_valid / out_ready
//
// One item at a time. Insert steps: accept, write, load.
// Remove: a registered scan of all held entries through the single read port of the
// entry store, then each entry above the minimum moved down one place, one per cycle.
// Empty remove or full insert: accept, then load.
// Reset clears the count and control; the entry store is not cleared.
// A new beat is taken while a result waits on out_ready; its own result holds until then.
`timescale 1ns / 1ps
`default_nettype none

module array_min_priority_queue import amq_pkg::*; #(
	parameter int DEPTH = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               command,
	input  wire logic signed [31:0] value_in,
	input  wire logic signed [15:0] priority_in,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic signed [31:0]      value_out,
	output logic signed [15:0]      priority_out,
	output logic [3:0]              occupancy
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	amq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	amq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.value_in     (value_in),
		.priority_in  (priority_in),
		.status       (status),
		.value_out    (value_out),
		.priority_out (priority_out),
		.occupancy    (occupancy)
	);

endmodule

`default_nettype wire
